FILE: hw/rtl/grfs_pkg.sv
// ----------------------------------------------------------------------------
// grfs_pkg
// Shared types, codes and constants of the occupancy grid ray update unit.
// ----------------------------------------------------------------------------
package grfs_pkg;

	// grid geometry default, column and row bits
	localparam int COORD_BITS_DEF = 8;

	// field widths
	localparam int FIELD_W = 8;
	localparam int CELL_W  = 8;
	localparam int STEP_W  = 7;
	localparam int CNT_W   = 8;
	localparam int CFG_W   = 8;

	// distance from a bound inside which the step is halved
	localparam int NEAR_BOUND = 10;

	typedef logic signed [CELL_W-1:0] cell_val_t;
	typedef logic [STEP_W-1:0]        step_t;

	typedef enum logic [1:0] {
		OP_RAY  = 2'd0,
		OP_READ = 2'd1,
		OP_MARK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_FREE_STEP     = 2'd0,
		REG_OCCUPIED_STEP = 2'd1,
		REG_CELL_FLOOR    = 2'd2,
		REG_CELL_CEILING  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [FIELD_W-1:0] start_x;
		logic [FIELD_W-1:0] start_y;
		logic [FIELD_W-1:0] end_x;
		logic [FIELD_W-1:0] end_y;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] cells_updated;
		cell_val_t        cell_value;
	} rsp_t;

	// top level sequencer
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_POINT,
		ST_POINT_WAIT,
		ST_DONE
	} seq_state_t;

	// line walker sequencer
	typedef enum logic [1:0] {
		W_IDLE,
		W_ABS,
		W_INIT,
		W_RUN
	} walk_state_t;

	// walker status toward the sequencer
	typedef struct packed {
		logic busy;
		logic cell_vld;
	} walk_stat_t;

endpackage

FILE: hw/rtl/grfs_ram.sv
// ----------------------------------------------------------------------------
// grfs_ram
// Generic simple dual port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module grfs_ram
	import grfs_pkg::*;
#(
	parameter int WIDTH = CELL_W,
	parameter int DEPTH = 1 << (2 * COORD_BITS_DEF),
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/grfs_cell_alu.sv
// ----------------------------------------------------------------------------
// grfs_cell_alu
// Shared saturating cell update: raise by the free step or drop by the
// occupied step, halving the step near the bound the cell moves away from.
// ----------------------------------------------------------------------------
module grfs_cell_alu
	import grfs_pkg::*;
(
	input  cell_val_t cur,
	input  logic      drop,
	input  step_t     free_step,
	input  step_t     occupied_step,
	input  cell_val_t cell_floor,
	input  step_t     cell_ceiling,
	output cell_val_t upd
);

	localparam logic signed [9:0] NB = 10'(NEAR_BOUND);

	step_t             step;
	logic signed [9:0] v_w;
	logic signed [9:0] fl_w;
	logic signed [9:0] ce_w;
	logic signed [9:0] s_w;
	logic signed [9:0] hs_w;
	logic signed [9:0] t_w;
	logic signed [9:0] n_w;

	always_comb begin
		step = drop ? occupied_step : free_step;
		v_w  = $signed({{2{cur[CELL_W-1]}}, cur});
		fl_w = $signed({{2{cell_floor[CELL_W-1]}}, cell_floor});
		ce_w = $signed({3'b000, cell_ceiling});
		s_w  = $signed({3'b000, step});
		// half step, never below one
		hs_w = (step[STEP_W-1:1] == '0) ? 10'sd1 : $signed({4'b0000, step[STEP_W-1:1]});
		t_w  = '0;
		if (!drop) begin
			if (v_w < fl_w + NB) begin
				t_w = v_w + hs_w;
				n_w = (t_w > ce_w) ? ce_w : t_w;
			end else if (v_w <= ce_w - s_w) begin
				n_w = v_w + s_w;
			end else begin
				n_w = ce_w;
			end
		end else begin
			if (v_w > ce_w - NB) begin
				t_w = v_w - hs_w;
				n_w = (t_w < fl_w) ? fl_w : t_w;
			end else if (v_w >= fl_w + s_w) begin
				n_w = v_w - s_w;
			end else begin
				n_w = fl_w;
			end
		end
		upd = n_w[CELL_W-1:0];
	end

endmodule

FILE: hw/rtl/grfs_line_walker.sv
// ----------------------------------------------------------------------------
// grfs_line_walker
// Integer line stepper: after W_ABS and W_INIT setup it emits one grid address
// per clock along the major axis, stopping before the end column or row.
// ----------------------------------------------------------------------------
module grfs_line_walker
	import grfs_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int AW = 2 * COORD_BITS,
	localparam int DW = COORD_BITS + 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cmd_t          cmd,
	output walk_stat_t    stat,
	output logic [AW-1:0] cell_addr
);

	walk_state_t state_q, state_d;

	logic [COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [COORD_BITS-1:0] dx_q, dy_q;
	logic                  x_up_q, y_up_q;
	logic                  steep_q, maj_up_q, min_up_q;
	logic [COORD_BITS-1:0] ma_q, mi_q, end_q;
	logic signed [DW-1:0]  d_q, inc_a_q, inc_b_q;
	logic                  cell_vld_q;
	logic [AW-1:0]         cell_addr_q;

	logic                  steep;
	logic [COORD_BITS-1:0] dmaj, dmin, mi_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			W_IDLE: begin
				if (start) begin
					state_d = W_ABS;
				end
			end
			W_ABS:  state_d = W_INIT;
			W_INIT: state_d = W_RUN;
			W_RUN: begin
				if (ma_q == end_q) begin
					state_d = W_IDLE;
				end
			end
			default: state_d = W_IDLE;
		endcase
	end

	always_comb begin
		steep = dx_q < dy_q;
		dmaj  = steep ? dy_q : dx_q;
		dmin  = steep ? dx_q : dy_q;
		if (d_q[DW-1]) begin
			mi_n = mi_q;
		end else begin
			mi_n = min_up_q ? mi_q + 1'b1 : mi_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_vld_q <= 1'b0;
		end else begin
			cell_vld_q <= (state_q == W_RUN) && (ma_q != end_q);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			W_IDLE: begin
				x1_q <= COORD_BITS'(cmd.start_x);
				y1_q <= COORD_BITS'(cmd.start_y);
				x2_q <= COORD_BITS'(cmd.end_x);
				y2_q <= COORD_BITS'(cmd.end_y);
			end
			W_ABS: begin
				dx_q   <= (x2_q > x1_q) ? x2_q - x1_q : x1_q - x2_q;
				dy_q   <= (y2_q > y1_q) ? y2_q - y1_q : y1_q - y2_q;
				x_up_q <= x2_q > x1_q;
				y_up_q <= y2_q > y1_q;
			end
			W_INIT: begin
				steep_q  <= steep;
				ma_q     <= steep ? y1_q : x1_q;
				mi_q     <= steep ? x1_q : y1_q;
				end_q    <= steep ? y2_q : x2_q;
				maj_up_q <= steep ? y_up_q : x_up_q;
				min_up_q <= steep ? x_up_q : y_up_q;
				d_q      <= $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
				inc_a_q  <= $signed({2'b00, dmin, 1'b0});
				inc_b_q  <= $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
			end
			W_RUN: begin
				if (ma_q != end_q) begin
					// minor axis decision first, then the visit, then the major step
					d_q         <= d_q[DW-1] ? d_q + inc_a_q : d_q + inc_b_q;
					mi_q        <= mi_n;
					cell_addr_q <= steep_q ? {ma_q, mi_n} : {mi_n, ma_q};
					ma_q        <= maj_up_q ? ma_q + 1'b1 : ma_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.busy     = state_q != W_IDLE;
	assign stat.cell_vld = cell_vld_q;
	assign cell_addr     = cell_addr_q;

endmodule

FILE: hw/rtl/grid_ray_free_space_update_unit.sv
// ----------------------------------------------------------------------------
// grid_ray_free_space_update_unit
// Occupancy grid of signed cells with ray cast, mark and read operations.
// ----------------------------------------------------------------------------
// The grid holds 2^(2*COORD_BITS) signed 8-bit cells in one RAM, cell (x, y)
// at address {y, x}. After reset a clearing pass writes every cell to zero,
// one per clock, so the block takes no transaction until the pass has reached
// the last cell; configuration writes are taken at any time. A ray cast walks
// the integer line from the start cell and raises each visited cell once,
// max(|dx|, |dy|) cells in all, at one cell per clock: the line walker issues
// a read, the shared update unit computes the new value from the registered
// read data and writes it back the next cycle. A ray passes through ST_WALK,
// read and mark through ST_POINT and ST_POINT_WAIT, and an unused operation
// code goes straight to ST_DONE, which loads the result into the output
// register. The read-modify-write on the single RAM read and write port sets
// the one cell per clock figure. Only one transaction is in work at a time;
// the next one is accepted as soon as the result of the last one sits in the
// output register, even if it has not been taken yet.
// ----------------------------------------------------------------------------
module grid_ray_free_space_update_unit
	import grfs_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// command channel
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	// result channel
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	// register write port
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int AW    = 2 * COORD_BITS;
	localparam int DEPTH = 1 << AW;

	// configuration registers
	step_t     free_step_q;
	step_t     occupied_step_q;
	cell_val_t cell_floor_q;
	step_t     cell_ceiling_q;

	// sequencer
	seq_state_t state_q, state_d;

	// transaction context
	logic [1:0]       op_q;
	logic [AW-1:0]    item_addr_q;
	logic [CNT_W-1:0] cnt_q;
	cell_val_t        val_q;

	// clearing pass
	logic [AW-1:0] clr_cnt_q;

	// ram access, read stage s1 is the cycle the read data shows up
	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;
	logic             rd_vld_s1;
	logic [AW-1:0]    addr_s1;

	// walker and update unit
	logic          walk_start;
	walk_stat_t    walk_stat;
	logic [AW-1:0] walk_addr;
	cell_val_t     alu_upd;
	logic          alu_drop;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic rsp_load;

	// ------------------------------------------------------------------------
	// register write port
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_step_q     <= 7'd2;
			occupied_step_q <= 7'd8;
			cell_floor_q    <= -8'sd128;
			cell_ceiling_q  <= 7'd127;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FREE_STEP:     free_step_q     <= cfg_data[STEP_W-1:0];
				REG_OCCUPIED_STEP: occupied_step_q <= cfg_data[STEP_W-1:0];
				REG_CELL_FLOOR:    cell_floor_q    <= $signed(cfg_data);
				REG_CELL_CEILING:  cell_ceiling_q  <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd_ready  = 1'b0;
		walk_start = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = item_addr_q;
		ram_we     = 1'b0;
		ram_waddr  = addr_s1;
		ram_wdata  = alu_upd;
		alu_drop   = 1'b0;
		rsp_load   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				// zero the grid one cell per clock
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
				if (&clr_cnt_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					case (cmd.operation) inside
						OP_RAY: begin
							walk_start = 1'b1;
							state_d    = ST_WALK;
						end
						OP_READ, OP_MARK: state_d = ST_POINT;
						default:          state_d = ST_DONE;
					endcase
				end
			end
			ST_WALK: begin
				// read the walker's cell, write back the raised value in the next cycle
				ram_re    = walk_stat.cell_vld;
				ram_raddr = walk_addr;
				ram_we    = rd_vld_s1;
				if (!walk_stat.busy && !walk_stat.cell_vld && !rd_vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_POINT: begin
				ram_re  = 1'b1;
				state_d = ST_POINT_WAIT;
			end
			ST_POINT_WAIT: begin
				alu_drop = 1'b1;
				ram_we   = op_q == OP_MARK;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				// hand over once the output register is free or being emptied
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------------
	// datapath
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			rd_vld_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ram_raddr;
		if (cmd_valid && cmd_ready) begin
			op_q        <= cmd.operation;
			item_addr_q <= {COORD_BITS'(cmd.start_y), COORD_BITS'(cmd.start_x)};
			cnt_q       <= '0;
			val_q       <= '0;
		end else if (state_q == ST_WALK && ram_we) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (state_q == ST_POINT_WAIT) begin
			if (op_q == OP_MARK) begin
				cnt_q <= CNT_W'(1);
				val_q <= alu_upd;
			end else begin
				val_q <= $signed(ram_rdata);
			end
		end
	end

	// ------------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.cells_updated <= cnt_q;
			rsp_q.cell_value    <= val_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ------------------------------------------------------------------------
	// units
	// ------------------------------------------------------------------------
	grfs_ram #(
		.WIDTH(CELL_W),
		.DEPTH(DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	grfs_line_walker #(
		.COORD_BITS(COORD_BITS)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (walk_start),
		.cmd      (cmd),
		.stat     (walk_stat),
		.cell_addr(walk_addr)
	);

	grfs_cell_alu u_alu (
		.cur          ($signed(ram_rdata)),
		.drop         (alu_drop),
		.free_step    (free_step_q),
		.occupied_step(occupied_step_q),
		.cell_floor   (cell_floor_q),
		.cell_ceiling (cell_ceiling_q),
		.upd          (alu_upd)
	);

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------

	// a read never hits the cell being written back in the same cycle
	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_vld_s1 && ram_re) |-> (ram_raddr != addr_s1))
		else $error("read and write back of the same cell collide");

	// the walker only hands out cells while the sequencer walks a ray
	a_walk_in_ray: assert property (@(posedge clk) disable iff (!arst_n)
		walk_stat.cell_vld |-> (state_q == ST_WALK))
		else $error("walker cell outside a ray transaction");

	// the walker only starts from an accepted ray command
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(walk_stat.busy) |-> ($past(state_q) == ST_IDLE && $past(cmd_valid)))
		else $error("walker started without a ray command");

	// no grid write while a new command can be accepted
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> (!ram_we && !rd_vld_s1))
		else $error("grid access still pending while idle");

endmodule

FILE: tb/grid_occupancy_shadow_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_occupancy_shadow_pkg
// Shadow occupancy grid that predicts and checks each result of the unit.
// ----------------------------------------------------------------------------
package grid_occupancy_shadow_pkg;
	import grfs_pkg::*;

	localparam int GRID_CELLS       = 1 << (2 * COORD_BITS_DEF);
	localparam int COORD_MASK       = (1 << COORD_BITS_DEF) - 1;
	localparam int SHOWN_MISMATCHES = 10;

	class occupancy_shadow;
		cell_val_t cells[GRID_CELLS];
		int        free_inc;
		int        occ_dec;
		int        floor_lim;
		int        ceil_lim;
		rsp_t      awaited[$];
		int        mismatches;

		function new();
			foreach (cells[i]) cells[i] = '0;
			free_inc   = 2;
			occ_dec    = 8;
			floor_lim  = -128;
			ceil_lim   = 127;
			mismatches = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_FREE_STEP:     free_inc  = int'(val[STEP_W-1:0]);
				REG_OCCUPIED_STEP: occ_dec   = int'(val[STEP_W-1:0]);
				REG_CELL_FLOOR:    floor_lim = int'(signed'(val));
				REG_CELL_CEILING:  ceil_lim  = int'(val[STEP_W-1:0]);
				default: ;
			endcase
		endfunction

		function int addr_of(int x, int y);
			return ((y & COORD_MASK) << COORD_BITS_DEF) | (x & COORD_MASK);
		endfunction

		// near a bound the step is halved, never below 1
		function int half_or_one(int s);
			return (s / 2 < 1) ? 1 : s / 2;
		endfunction

		function void raise_free(int x, int y);
			int a;
			int v;
			int n;
			a = addr_of(x, y);
			v = cells[a];
			if (v < floor_lim + NEAR_BOUND) begin
				n = v + half_or_one(free_inc);
				if (n > ceil_lim) n = ceil_lim;
			end else if (v <= ceil_lim - free_inc) begin
				n = v + free_inc;
			end else begin
				n = ceil_lim;
			end
			cells[a] = cell_val_t'(n);
		endfunction

		function int lower_occupied(int x, int y);
			int a;
			int v;
			int n;
			a = addr_of(x, y);
			v = cells[a];
			if (v > ceil_lim - NEAR_BOUND) begin
				n = v - half_or_one(occ_dec);
				if (n < floor_lim) n = floor_lim;
			end else if (v >= floor_lim + occ_dec) begin
				n = v - occ_dec;
			end else begin
				n = floor_lim;
			end
			cells[a] = cell_val_t'(n);
			return n;
		endfunction

		// integer line walk along the major axis, end column excluded
		function int walk_ray(int x1, int y1, int x2, int y2);
			int dx;
			int dy;
			int t;
			int step_a;
			int step_b;
			int err;
			int ma;
			int mi;
			int cnt;
			bit steep;
			dx    = x2 > x1 ? x2 - x1 : x1 - x2;
			dy    = y2 > y1 ? y2 - y1 : y1 - y2;
			steep = dx < dy;
			if (steep) begin
				t = x1; x1 = y1; y1 = t;
				t = x2; x2 = y2; y2 = t;
				t = dx; dx = dy; dy = t;
			end
			step_a = (x2 - x1) > 0 ? 1 : -1;
			step_b = (y2 - y1) > 0 ? 1 : -1;
			ma     = x1;
			mi     = y1;
			err    = 2 * dy - dx;
			cnt    = 0;
			while (ma != x2) begin
				if (err < 0) begin
					err += 2 * dy;
				end else begin
					mi  += step_b;
					err += 2 * (dy - dx);
				end
				if (steep) raise_free(mi, ma);
				else raise_free(ma, mi);
				cnt++;
				ma += step_a;
			end
			return cnt;
		endfunction

		function void note_command(cmd_t c);
			rsp_t r;
			int   x0;
			int   y0;
			int   x1;
			int   y1;
			x0 = int'(c.start_x) & COORD_MASK;
			y0 = int'(c.start_y) & COORD_MASK;
			x1 = int'(c.end_x) & COORD_MASK;
			y1 = int'(c.end_y) & COORD_MASK;
			r  = '0;
			case (c.operation)
				OP_RAY:  r.cells_updated = CNT_W'(walk_ray(x0, y0, x1, y1));
				OP_READ: r.cell_value = cells[addr_of(x0, y0)];
				OP_MARK: begin
					r.cell_value    = cell_val_t'(lower_occupied(x0, y0));
					r.cells_updated = CNT_W'(1);
				end
				default: ;
			endcase
			awaited = {awaited, r};
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("unexpected result: cells_updated %0d cell_value %0d",
						got.cells_updated, got.cell_value);
				return;
			end
			want = awaited.pop_front();
			if (got.cells_updated !== want.cells_updated ||
				got.cell_value !== want.cell_value) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display({"result mismatch: cells_updated exp %0d got %0d, ",
						"cell_value exp %0d got %0d"},
						want.cells_updated, got.cells_updated, want.cell_value, got.cell_value);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void count_missing();
			if (awaited.size() != 0) begin
				mismatches += awaited.size();
				$display("%0d results never arrived", awaited.size());
			end
		endfunction
	endclass

endpackage

FILE: tb/grid_ray_free_space_update_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_ray_free_space_update_unit_test
// Self-checking bench for the occupancy grid ray update unit.
// ----------------------------------------------------------------------------
// A shadow grid predicts every result from the accepted commands and the
// register settings. A short directed run covers the grid corners, shallow and
// steep lines both ways in x, empty and single-cell rays, read, mark and the
// unused code. Random phases follow, each after the first under new register
// settings written while the unit is idle; most commands hit a small hot area
// so cells reach both bounds. Both channels idle at random, first mostly on
// the result side, then mostly on the command side, then not at all.
// ----------------------------------------------------------------------------
module grid_ray_free_space_update_unit_test;
	import grfs_pkg::*;
	import grid_occupancy_shadow_pkg::*;

	// code without an operation behind it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int RESET_CYCLES    = 5;
	localparam int PHASES          = 9;
	localparam int ITEMS_PER_PHASE = 106;
	localparam int RANDOM_ITEMS    = PHASES * ITEMS_PER_PHASE;
	// longest ray plus pipeline, waited out before the verdict
	localparam int TAIL_CYCLES     = 270;
	// no command is accepted during the clearing pass after reset
	localparam int WATCHDOG_LIMIT  = 200000;

	logic             clk;
	logic             arst_n;
	logic             cmd_valid;
	logic             cmd_ready;
	cmd_t             cmd;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_t             rsp;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	occupancy_shadow    shadow;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	int                 stall_cycles = 0;
	logic [FIELD_W-1:0] hot_x;
	logic [FIELD_W-1:0] hot_y;

	grid_ray_free_space_update_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// transaction monitor, result side stall and watchdog
	// values read here are the ones present at the edge
	always @(posedge clk) begin
		if (cmd_valid && cmd_ready) shadow.note_command(cmd);
		if (rsp_valid && rsp_ready) shadow.check_response(rsp);
		rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic cmd_t pack_cmd(input logic [1:0] op,
		input logic [FIELD_W-1:0] x0, y0, x1, y1);
		cmd_t c;
		c.operation = op;
		c.start_x   = x0;
		c.start_y   = y0;
		c.end_x     = x1;
		c.end_y     = y1;
		return c;
	endfunction

	// mostly near the hot area, so the same cells are hit over and over
	function automatic logic [FIELD_W-1:0] pick_coord(input logic [FIELD_W-1:0] hot);
		if ($urandom_range(0, 99) < 70) return hot + FIELD_W'($urandom_range(0, 7));
		return FIELD_W'($urandom_range(0, 255));
	endfunction

	function automatic cmd_t random_cmd();
		int unsigned        roll;
		logic [1:0]         op;
		logic [FIELD_W-1:0] x0, y0, x1, y1;
		roll = $urandom_range(0, 99);
		if (roll < 40) op = OP_RAY;
		else if (roll < 65) op = OP_MARK;
		else if (roll < 95) op = OP_READ;
		else op = OP_UNUSED;
		x0 = pick_coord(hot_x);
		y0 = pick_coord(hot_y);
		// short rays mostly; wrap at the grid edge gives a few long ones
		if ($urandom_range(0, 99) < 85) begin
			x1 = x0 + FIELD_W'($urandom_range(0, 24)) - FIELD_W'(12);
			y1 = y0 + FIELD_W'($urandom_range(0, 24)) - FIELD_W'(12);
		end else begin
			x1 = FIELD_W'($urandom_range(0, 255));
			y1 = FIELD_W'($urandom_range(0, 255));
		end
		return pack_cmd(op, x0, y0, x1, y1);
	endfunction

	// valid stays up from one command to the next unless the sender idles
	task automatic send_command(input cmd_t c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
	endtask

	// every command gives one result, so an empty queue means idle
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (shadow.pending() != 0);
	endtask

	// write enable stays high across a burst, program_regs lowers it
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		shadow.set_reg(idx, val);
	endtask

	task automatic program_regs(input logic [CFG_W-1:0] free_v, occ_v, floor_v, ceil_v);
		write_reg(REG_FREE_STEP, free_v);
		write_reg(REG_OCCUPIED_STEP, occ_v);
		write_reg(REG_CELL_FLOOR, floor_v);
		write_reg(REG_CELL_CEILING, ceil_v);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(input int k);
		case (k)
			// largest steps, widest bounds
			0: program_regs(8'd127, 8'd127, 8'h80, 8'd127);
			// zero steps, both bounds at zero
			1: program_regs(8'd0, 8'd0, 8'd0, 8'd0);
			2: program_regs(8'd1, 8'd1, 8'h80, 8'd127);
			// floor above zero and above the ceiling
			3: program_regs(8'd5, 8'd20, 8'd100, 8'd20);
			// top data bit set on the two step registers
			4: program_regs(8'd200, 8'hff, 8'hce, 8'd60);
			// back to the reset values
			7: program_regs(8'd2, 8'd8, 8'h80, 8'd127);
			default: begin
				program_regs(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)),
					($urandom_range(0, 3) != 0) ? CFG_W'(0 - int'($urandom_range(0, 128)))
						: CFG_W'($urandom_range(0, 255)),
					CFG_W'($urandom_range(0, 255)));
			end
		endcase
	endtask

	initial begin
		int p;
		int i;
		int sent;
		shadow        = new();
		arst_n        = 1'b0;
		cmd_valid     = 1'b0;
		cmd           = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		send_idle_pct = 33;
		recv_idle_pct = 53;
		hot_x         = '0;
		hot_y         = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corners, shallow and steep lines, empty and single-cell rays
		send_command(pack_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0));
		send_command(pack_cmd(OP_READ, 8'd255, 8'd255, 8'd255, 8'd255));
		send_command(pack_cmd(OP_RAY, 8'd0, 8'd0, 8'd255, 8'd0));
		send_command(pack_cmd(OP_RAY, 8'd255, 8'd255, 8'd0, 8'd255));
		send_command(pack_cmd(OP_RAY, 8'd0, 8'd0, 8'd0, 8'd255));
		send_command(pack_cmd(OP_RAY, 8'd255, 8'd0, 8'd0, 8'd255));
		send_command(pack_cmd(OP_RAY, 8'd0, 8'd0, 8'd255, 8'd255));
		send_command(pack_cmd(OP_RAY, 8'd10, 8'd10, 8'd13, 8'd20));
		send_command(pack_cmd(OP_RAY, 8'd20, 8'd20, 8'd13, 8'd17));
		send_command(pack_cmd(OP_RAY, 8'd50, 8'd60, 8'd49, 8'd80));
		send_command(pack_cmd(OP_RAY, 8'd40, 8'd40, 8'd40, 8'd40));
		send_command(pack_cmd(OP_RAY, 8'd100, 8'd100, 8'd101, 8'd100));
		send_command(pack_cmd(OP_READ, 8'd1, 8'd1, 8'd200, 8'd7));
		send_command(pack_cmd(OP_MARK, 8'd1, 8'd1, 8'd0, 8'd0));
		send_command(pack_cmd(OP_MARK, 8'd255, 8'd255, 8'd255, 8'd255));
		send_command(pack_cmd(OP_READ, 8'd255, 8'd255, 8'd0, 8'd0));
		send_command(pack_cmd(OP_UNUSED, 8'd0, 8'd0, 8'd255, 8'd255));
		send_command(pack_cmd(OP_MARK, 8'd0, 8'd0, 8'd0, 8'd0));
		send_command(pack_cmd(OP_READ, 8'd100, 8'd100, 8'd0, 8'd0));

		// random phases, registers rewritten only with nothing in flight
		sent = 0;
		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			if (p != 0) apply_setting(p - 1);
			// keep the old hot area now and then, so filled cells meet new bounds
			if (p == 0 || $urandom_range(0, 1) == 1) begin
				hot_x = FIELD_W'($urandom_range(0, 255));
				hot_y = FIELD_W'($urandom_range(0, 255));
			end
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (sent < RANDOM_ITEMS / 3) begin
					send_idle_pct = 33;
					recv_idle_pct = 53;
				end else if (sent < 2 * RANDOM_ITEMS / 3) begin
					send_idle_pct = 53;
					recv_idle_pct = 33;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				send_command(random_cmd());
				sent++;
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		shadow.count_missing();
		if (shadow.mismatches == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
